@@ rtl/core/lru_key_value_cache_macros.svh @@
// Assertion helpers shared by the cache RTL.
// Each expects clk_i and rst_ni in scope.
`ifndef LRU_KEY_VALUE_CACHE_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define LKV_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define LKV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/lkv_pkg.sv @@
`timescale 1ns / 1ps
package lkv_pkg;

  localparam int unsigned DEF_ENTRIES    = 16;
  localparam int unsigned DEF_KEY_BITS   = 32;
  localparam int unsigned DEF_VALUE_BITS = 32;

  localparam int unsigned CAP_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // capture request payload
    logic lookup;    // register match, victim and free-slot vectors
    logic update;    // commit store changes, launch value read
    logic load_out;  // move result into the output register
  } cmd_t;

endpackage

@@ rtl/core/lkv_req_if.sv @@
`timescale 1ns / 1ps
interface lkv_req_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  kind;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

@@ rtl/core/lkv_rsp_if.sv @@
`timescale 1ns / 1ps
interface lkv_rsp_if #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

@@ rtl/core/lkv_cfg_if.sv @@
`timescale 1ns / 1ps
interface lkv_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// Fully associative key/value cache with least-recently-used replacement.
// A request is a get (kind 0) or a put (kind 1); every request yields exactly
// one result. A request passes four steps from acceptance to a loaded result:
// accept, parallel key compare against all entries, commit of the store and
// recency ranks (with the value RAM read for a get hit), and result load. A new
// request enters only once the last has loaded its result; a result waiting in
// the output register does not block the next request from entering. Keys and
// recency ranks live in flip-flops, values in a RAM. All entries are invalid
// after reset and no clearing pass is needed. The user must write the capacity
// register (reset 16, 0 acts as 1, values above ENTRIES saturate) through the
// config channel only while no request is in flight; the block does not enforce it.
module lru_key_value_cache #(
  parameter int unsigned ENTRIES    = lkv_pkg::DEF_ENTRIES,
  parameter int unsigned KEY_BITS   = lkv_pkg::DEF_KEY_BITS,
  parameter int unsigned VALUE_BITS = lkv_pkg::DEF_VALUE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  lkv_req_if.sink      req_i,
  lkv_rsp_if.source    rsp_o,
  lkv_cfg_if.sink      cfg_i
);
  import lkv_pkg::*;

  cmd_t cmd;

  assign cfg_i.ready = 1'b1;

  lkv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  lkv_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (req_i.kind),
    .key_i         (req_i.key),
    .value_i       (req_i.value),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .hit_o         (rsp_o.hit),
    .read_value_o  (rsp_o.read_value),
    .evicted_o     (rsp_o.evicted),
    .evicted_key_o (rsp_o.evicted_key)
  );
endmodule

@@ rtl/core/lkv_ram.sv @@
`timescale 1ns / 1ps
module lkv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/lkv_ctrl.sv @@
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"
module lkv_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  output lkv_pkg::cmd_t cmd_o
);
  import lkv_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.accept    = (state_q == S_IDLE) && req_valid_i;
    cmd_o.lookup    = (state_q == S_LOOKUP);
    cmd_o.update    = (state_q == S_UPDATE);
    cmd_o.load_out  = (state_q == S_DONE) && out_free;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          state_d = S_LOOKUP;
        end
      end
      S_LOOKUP: state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output register holds a result until taken; the next request may enter meanwhile
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = out_valid_q;

  `LKV_ASSERT_NEXT(a_accept_to_lookup, req_valid_i && req_ready_o, state_q == S_LOOKUP, "request accepted but no lookup followed")
  `LKV_ASSERT_NEXT(a_lookup_to_update, state_q == S_LOOKUP, state_q == S_UPDATE, "lookup not followed by update")
  `LKV_ASSERT_NEXT(a_load_shows_result, cmd_o.load_out, rsp_valid_o, "result loaded but not presented")
endmodule

@@ rtl/core/lkv_datapath.sv @@
`timescale 1ns / 1ps
`include "lru_key_value_cache_macros.svh"
module lkv_datapath #(
  parameter int unsigned ENTRIES    = 16,
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lkv_pkg::cmd_t                 cmd_i,
  input  logic                          kind_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [VALUE_BITS-1:0]         value_i,
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::CAP_BITS-1:0]  cfg_data_i,
  output logic                          hit_o,
  output logic [VALUE_BITS-1:0]         read_value_o,
  output logic                          evicted_o,
  output logic [KEY_BITS-1:0]           evicted_key_o
);
  import lkv_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_BITS) ? CNT_W : CAP_BITS;

  // request capture
  logic                  kind_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // store state
  logic [KEY_BITS-1:0]   keys_q [ENTRIES];
  logic [ENTRIES-1:0]    valid_q;
  logic [IDX_W-1:0]      rank_q [ENTRIES];
  logic [IDX_W-1:0]      rank_d [ENTRIES];
  logic [CNT_W-1:0]      occ_q;
  logic [CAP_BITS-1:0]   cap_q;

  // lookup results
  logic [ENTRIES-1:0]    hit_vec_q, victim_vec_q, free_vec_q;
  logic                  evict_q;
  logic [ENTRIES-1:0]    match_vec, victim_vec, free_vec, inv_vec;
  logic [CMP_W-1:0]      eff_cap;
  logic [IDX_W-1:0]      occ_m1;

  // update decode
  logic [IDX_W-1:0]      hidx, vidx, fidx, slot;
  logic [IDX_W-1:0]      thr;
  logic                  any_hit, is_put, do_insert, do_evict;

  // pending result
  logic                  res_hit_q, res_get_hit_q, res_evict_q;
  logic [KEY_BITS-1:0]   res_evk_q;

  logic [VALUE_BITS-1:0] ram_rdata;
  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(cap_q) > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = CMP_W'(cap_q);
    end
  end

  // ranks of valid entries are distinct, so the oldest is the one ranked occupancy-1
  assign occ_m1 = IDX_W'(occ_q - CNT_W'(1));
  assign inv_vec  = ~valid_q;
  assign free_vec = inv_vec & (~inv_vec + ENTRIES'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_vec[i]  = valid_q[i] && (keys_q[i] == key_q);
      victim_vec[i] = valid_q[i] && (rank_q[i] == occ_m1);
    end
  end

  always_comb begin
    hidx = '0;
    vidx = '0;
    fidx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_q[i])    hidx = hidx | IDX_W'(i);
      if (victim_vec_q[i]) vidx = vidx | IDX_W'(i);
      if (free_vec_q[i])   fidx = fidx | IDX_W'(i);
    end
  end

  assign any_hit   = |hit_vec_q;
  assign is_put    = (kind_q == KIND_PUT);
  assign do_insert = cmd_i.update && !any_hit && is_put;
  assign do_evict  = !any_hit && is_put && evict_q;
  assign slot      = evict_q ? vidx : fidx;
  assign thr       = rank_q[hidx];

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
    end
    if (cmd_i.update && any_hit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (IDX_W'(i) != hidx) && (rank_q[i] < thr)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      rank_d[hidx] = '0;
    end else if (do_insert) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (valid_q[i] && (IDX_W'(i) != slot)) begin
          rank_d[i] = rank_q[i] + IDX_W'(1);
        end
      end
      rank_d[slot] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
      cap_q   <= CAP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
      if (do_insert) begin
        valid_q[slot] <= 1'b1;
        if (!evict_q) begin
          occ_q <= occ_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q  <= kind_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (cmd_i.lookup) begin
      hit_vec_q    <= match_vec;
      victim_vec_q <= victim_vec;
      free_vec_q   <= free_vec;
      evict_q      <= (CMP_W'(occ_q) >= eff_cap);
    end
    if (do_insert) begin
      keys_q[slot] <= key_q;
    end
    if (cmd_i.update) begin
      res_hit_q     <= any_hit;
      res_get_hit_q <= any_hit && !is_put;
      res_evict_q   <= do_evict;
      res_evk_q     <= do_evict ? keys_q[vidx] : '0;
    end
    if (cmd_i.load_out) begin
      hit_o         <= res_hit_q;
      read_value_o  <= res_get_hit_q ? ram_rdata : '0;
      evicted_o     <= res_evict_q;
      evicted_key_o <= res_evk_q;
    end
  end

  assign ram_we    = cmd_i.update && is_put;
  assign ram_re    = cmd_i.update && any_hit && !is_put;
  assign ram_waddr = any_hit ? hidx : slot;

  lkv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ENTRIES)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_q),
    .re_i    (ram_re),
    .raddr_i (hidx),
    .rdata_o (ram_rdata)
  );

  `LKV_ASSERT_IMP(a_keys_unique, cmd_i.update, $onehot0(hit_vec_q), "key in two entries")
  `LKV_ASSERT_ALWAYS(a_occ_count, occ_q == CNT_W'($countones(valid_q)), "occupancy off")
  `LKV_ASSERT_IMP(a_evict_has_victim, cmd_i.update && do_evict, $onehot(victim_vec_q), "no oldest")
endmodule
